/* src/thpc_pkg.sv */
package thpc_pkg;

  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;
  localparam int QueueDepth = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_TEMP_COEFFS    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_COEFFS_A = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_COEFFS_B = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MIXED_COEFFS   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HUM_COEFFS     = 3'd4;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } raw_word_t;

  typedef struct packed {
    logic [17:0] temperature_centideg;
    logic [23:0] pressure_pascal;
    logic [13:0] humidity_centipercent;
    logic        pressure_divisor_zero;
  } result_t;

  typedef struct packed {
    logic [47:0] temp_coeffs;
    logic [63:0] press_coeffs_a;
    logic [63:0] press_coeffs_b;
    logic [47:0] mixed_coeffs;
    logic [39:0] hum_coeffs;
  } coeffs_t;

endpackage

/* src/thpc_front.sv */
module thpc_front import thpc_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  raw_word_t in_word_i,
  output logic      word_valid_o,
  output raw_word_t word_o,
  input  logic      word_pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  raw_word_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign in_stall_o   = (cnt_q == CntW'(Depth));
  assign push         = in_valid_i & ~in_stall_o;
  assign word_valid_o = (cnt_q != '0);
  assign pop          = word_pop_i & word_valid_o;
  assign word_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_word_i;
    end
  end

endmodule

/* src/thpc_mul.sv */
module thpc_mul import thpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  // low 64 bits of a 64x64 product from three 32x32 partial products
  logic [63:0] a_q, b_q, prod_q, acc_q;
  logic [1:0]  cnt_q;
  logic        run_q, done_q;
  logic [31:0] op_x, op_y;

  always_comb begin
    op_x = a_q[31:0];
    op_y = b_q[31:0];
    unique case (cnt_q)
      2'd1:    op_y = b_q[63:32];
      2'd2:    op_x = a_q[63:32];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 2'd3) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (run_q) begin
      prod_q <= op_x * op_y;
      unique case (cnt_q)
        2'd0:    acc_q <= acc_q;
        2'd1:    acc_q <= prod_q;
        default: acc_q <= acc_q + {prod_q[31:0], 32'b0};
      endcase
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

/* src/thpc_div.sv */
module thpc_div import thpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] q_o
);

  // signed restoring division, one quotient bit a cycle, truncates toward zero
  logic [64:0] rem_q, trial;
  logic [63:0] quo_q, div_q;
  logic [5:0]  cnt_q;
  logic        neg_q, run_q, fix_q, done_q;
  logic        fits;

  assign trial = {rem_q[63:0], quo_q[63]};
  assign fits  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      fix_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 6'd63) begin
          run_q <= 1'b0;
          fix_q <= 1'b1;
        end
      end else if (fix_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= a_i[63] ? 64'd0 - a_i : a_i;
      div_q <= b_i[63] ? 64'd0 - b_i : b_i;
      neg_q <= a_i[63] ^ b_i[63];
      rem_q <= '0;
    end else if (run_q) begin
      rem_q <= fits ? trial - {1'b0, div_q} : trial;
      quo_q <= {quo_q[62:0], fits};
    end else if (fix_q) begin
      quo_q <= neg_q ? 64'd0 - quo_q : quo_q;
    end
  end

  assign done_o = done_q;
  assign q_o    = quo_q;

endmodule

/* src/thpc_back.sv */
module thpc_back import thpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  coeffs_t   coeffs_i,
  input  logic      word_valid_i,
  input  raw_word_t word_i,
  output logic      word_pop_o,
  output logic      res_valid_o,
  input  logic      res_stall_i,
  output result_t   res_o
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ISSUE = 4'b0010,
    PH_WAIT  = 4'b0100,
    PH_OUT   = 4'b1000
  } phase_e;

  typedef enum logic [22:0] {
    S_T0   = 23'h000001,
    S_T1   = 23'h000002,
    S_T2   = 23'h000004,
    S_T3   = 23'h000008,
    S_P0   = 23'h000010,
    S_P1   = 23'h000020,
    S_P2   = 23'h000040,
    S_P3   = 23'h000080,
    S_P4   = 23'h000100,
    S_P5   = 23'h000200,
    S_P6   = 23'h000400,
    S_PDIV = 23'h000800,
    S_P7   = 23'h001000,
    S_P8   = 23'h002000,
    S_P9   = 23'h004000,
    S_H0   = 23'h008000,
    S_H1   = 23'h010000,
    S_H2   = 23'h020000,
    S_H3   = 23'h040000,
    S_H4   = 23'h080000,
    S_H5   = 23'h100000,
    S_H6   = 23'h200000,
    S_H7   = 23'h400000
  } step_e;

  function automatic logic [31:0] sra32(input logic [31:0] v, input int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] v, input int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  phase_e phase_q;
  step_e  step_q;

  raw_word_t   word_q;
  logic [31:0] v1_q, r_q, tf_q, x_q, ha_q, hb_q, hc_q, he_q;
  logic [17:0] temp_q;
  logic [63:0] q1_q, qq_q, q2_q, u_q, den_q, pv_q, a1_q;
  logic [23:0] press_q;
  logic        dz_q;
  result_t     res_q;
  logic        res_valid_q;

  logic [63:0] op_a, op_b, mul_p, div_q, den_d, press_sum;
  logic        mul_start, div_start, mul_done, div_done, unit_done;
  logic [31:0] m32, hum_x;
  logic [26:0] hum_scaled;
  logic        load_res;

  // coefficient fields
  logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'b0, coeffs_i.temp_coeffs[15:0]};
  assign t2 = {{16{coeffs_i.temp_coeffs[31]}}, coeffs_i.temp_coeffs[31:16]};
  assign t3 = {{16{coeffs_i.temp_coeffs[47]}}, coeffs_i.temp_coeffs[47:32]};
  assign p1 = {48'b0, coeffs_i.press_coeffs_a[15:0]};
  assign p2 = {{48{coeffs_i.press_coeffs_a[31]}}, coeffs_i.press_coeffs_a[31:16]};
  assign p3 = {{48{coeffs_i.press_coeffs_a[47]}}, coeffs_i.press_coeffs_a[47:32]};
  assign p4 = {{48{coeffs_i.press_coeffs_a[63]}}, coeffs_i.press_coeffs_a[63:48]};
  assign p5 = {{48{coeffs_i.press_coeffs_b[15]}}, coeffs_i.press_coeffs_b[15:0]};
  assign p6 = {{48{coeffs_i.press_coeffs_b[31]}}, coeffs_i.press_coeffs_b[31:16]};
  assign p7 = {{48{coeffs_i.press_coeffs_b[47]}}, coeffs_i.press_coeffs_b[47:32]};
  assign p8 = {{48{coeffs_i.press_coeffs_b[63]}}, coeffs_i.press_coeffs_b[63:48]};
  assign p9 = {{48{coeffs_i.mixed_coeffs[15]}}, coeffs_i.mixed_coeffs[15:0]};
  assign h1 = {24'b0, coeffs_i.mixed_coeffs[23:16]};
  assign h2 = {{16{coeffs_i.mixed_coeffs[39]}}, coeffs_i.mixed_coeffs[39:24]};
  assign h3 = {24'b0, coeffs_i.mixed_coeffs[47:40]};
  assign h4 = {{16{coeffs_i.hum_coeffs[15]}}, coeffs_i.hum_coeffs[15:0]};
  assign h5 = {{16{coeffs_i.hum_coeffs[31]}}, coeffs_i.hum_coeffs[31:16]};
  assign h6 = {{24{coeffs_i.hum_coeffs[39]}}, coeffs_i.hum_coeffs[39:32]};

  thpc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  thpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .a_i    (pv_q),
    .b_i    (den_q),
    .done_o (div_done),
    .q_o    (div_q)
  );

  assign mul_start = (phase_q == PH_ISSUE) && (step_q != S_PDIV);
  assign div_start = (phase_q == PH_ISSUE) && (step_q == S_PDIV);
  assign unit_done = (step_q == S_PDIV) ? div_done : mul_done;
  assign word_pop_o = (phase_q == PH_IDLE) && word_valid_i;
  assign m32       = mul_p[31:0];
  assign den_d     = sra64(mul_p, 33);
  assign press_sum = sra64(u_q, 8) + (p7 << 4);

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_q)
      S_T0: begin
        op_a = {32'b0, 32'(word_q.raw_temperature[19:3]) - {15'b0, t1[15:0], 1'b0}};
        op_b = {32'b0, t2};
      end
      S_T1: begin
        op_a = {32'b0, 32'(word_q.raw_temperature[19:4]) - t1};
        op_b = op_a;
      end
      S_T2: begin op_a = {32'b0, r_q};  op_b = {32'b0, t3}; end
      S_T3: begin op_a = {32'b0, tf_q}; op_b = 64'd5; end
      S_P0: begin op_a = q1_q; op_b = q1_q; end
      S_P1: begin op_a = qq_q; op_b = p6; end
      S_P2: begin op_a = q1_q; op_b = p5; end
      S_P3: begin op_a = qq_q; op_b = p3; end
      S_P4: begin op_a = q1_q; op_b = p2; end
      S_P5: begin op_a = (64'd1 << 47) + u_q; op_b = p1; end
      S_P6: begin
        op_a = ((64'd1048576 - 64'(word_q.raw_pressure)) << 31) - q2_q;
        op_b = 64'd3125;
      end
      S_PDIV: ;
      S_P7: begin op_a = sra64(pv_q, 13); op_b = op_a; end
      S_P8: begin op_a = qq_q; op_b = p9; end
      S_P9: begin op_a = p8;   op_b = pv_q; end
      S_H0: begin op_a = {32'b0, h5};   op_b = {32'b0, x_q}; end
      S_H1: begin op_a = {32'b0, x_q};  op_b = {32'b0, h6}; end
      S_H2: begin op_a = {32'b0, x_q};  op_b = {32'b0, h3}; end
      S_H3: begin op_a = {32'b0, hb_q}; op_b = {32'b0, hc_q}; end
      S_H4: begin op_a = {32'b0, he_q}; op_b = {32'b0, h2}; end
      S_H5: begin op_a = {32'b0, ha_q}; op_b = {32'b0, he_q}; end
      S_H6: begin op_a = {32'b0, r_q};  op_b = {32'b0, r_q}; end
      S_H7: begin op_a = {32'b0, r_q};  op_b = {32'b0, h1}; end
      default: ;
    endcase
  end

  // clamp and scale humidity
  always_comb begin
    hum_x = x_q;
    if (x_q[31]) begin
      hum_x = '0;
    end else if (x_q > 32'd419430400) begin
      hum_x = 32'd419430400;
    end
    hum_scaled = 27'(hum_x[31:12]) * 27'd100;
  end

  assign load_res = (phase_q == PH_OUT) && (!res_valid_q || !res_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      step_q      <= S_T0;
      res_valid_q <= 1'b0;
    end else begin
      if (load_res) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (phase_q)
        PH_IDLE: begin
          if (word_valid_i) begin
            step_q  <= S_T0;
            phase_q <= PH_ISSUE;
          end
        end
        PH_ISSUE: phase_q <= PH_WAIT;
        PH_WAIT: begin
          if (unit_done) begin
            phase_q <= (step_q == S_H7) ? PH_OUT : PH_ISSUE;
            unique case (step_q)
              S_T0:   step_q <= S_T1;
              S_T1:   step_q <= S_T2;
              S_T2:   step_q <= S_T3;
              S_T3:   step_q <= S_P0;
              S_P0:   step_q <= S_P1;
              S_P1:   step_q <= S_P2;
              S_P2:   step_q <= S_P3;
              S_P3:   step_q <= S_P4;
              S_P4:   step_q <= S_P5;
              S_P5:   step_q <= (den_d == '0) ? S_H0 : S_P6;
              S_P6:   step_q <= S_PDIV;
              S_PDIV: step_q <= S_P7;
              S_P7:   step_q <= S_P8;
              S_P8:   step_q <= S_P9;
              S_P9:   step_q <= S_H0;
              S_H0:   step_q <= S_H1;
              S_H1:   step_q <= S_H2;
              S_H2:   step_q <= S_H3;
              S_H3:   step_q <= S_H4;
              S_H4:   step_q <= S_H5;
              S_H5:   step_q <= S_H6;
              S_H6:   step_q <= S_H7;
              S_H7:   step_q <= S_T0;
              default: step_q <= S_T0;
            endcase
          end
        end
        PH_OUT: begin
          if (load_res) begin
            phase_q <= PH_IDLE;
          end
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (word_pop_o) begin
      word_q <= word_i;
    end
    if (load_res) begin
      res_q.temperature_centideg  <= temp_q;
      res_q.pressure_pascal       <= press_q;
      res_q.humidity_centipercent <= hum_scaled[23:10];
      res_q.pressure_divisor_zero <= dz_q;
    end
    if (phase_q == PH_WAIT && unit_done) begin
      unique case (step_q)
        S_T0: v1_q <= sra32(m32, 11);
        S_T1: r_q  <= sra32(m32, 12);
        S_T2: tf_q <= v1_q + sra32(m32, 14);
        S_T3: begin
          temp_q <= 18'(sra32(m32 + 32'd128, 8));
          q1_q   <= {{32{tf_q[31]}}, tf_q} - 64'd128000;
          x_q    <= tf_q - 32'd76800;
        end
        S_P0: qq_q <= mul_p;
        S_P1: q2_q <= mul_p + (p4 << 35);
        S_P2: q2_q <= q2_q + (mul_p << 17);
        S_P3: u_q  <= sra64(mul_p, 8);
        S_P4: u_q  <= u_q + (mul_p << 12);
        S_P5: begin
          den_q <= den_d;
          dz_q  <= (den_d == '0);
        end
        S_P6:   pv_q <= mul_p;
        S_PDIV: pv_q <= div_q;
        S_P7:   qq_q <= mul_p;
        S_P8:   a1_q <= sra64(mul_p, 25);
        S_P9:   u_q  <= pv_q + a1_q + sra64(mul_p, 19);
        S_H0: begin
          ha_q    <= sra32((32'(word_q.raw_humidity) << 14) - (h4 << 20) - m32
                           + 32'd16384, 15);
          // finish pressure from the sum left by the last pressure step
          press_q <= dz_q ? '0 : 24'(sra64(press_sum, 8));
        end
        S_H1: hb_q <= sra32(m32, 10);
        S_H2: hc_q <= sra32(m32, 11) + 32'd32768;
        S_H3: he_q <= sra32(m32, 10) + 32'd2097152;
        S_H4: he_q <= sra32(m32 + 32'd8192, 14);
        S_H5: begin
          x_q <= m32;
          r_q <= sra32(m32, 15);
        end
        S_H6: r_q <= sra32(m32, 7);
        S_H7: x_q <= x_q - sra32(m32, 4);
        default: ;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* src/thp_sensor_compensation.sv */
// channel   direction  handshake                 word
// in        input      in_valid_i / in_stall_o   raw_temperature, raw_pressure, raw_humidity
// out       output     out_valid_o / out_stall_i temperature, pressure, humidity, divisor flag
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Each word runs through one 32x32 multiplier, used three times per 64-bit product, and
// a one-bit-a-cycle divider; a zero pressure divisor skips the divide.
// A queue ahead of the sequencer takes a new word while one is in work, unless it is full.
// Reset clears the coefficients to zero and empties the queue and output register.
// A stalled output holds its word; the sequencer waits only when that register is full.
module thp_sensor_compensation import thpc_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [19:0]         raw_temperature_i,
  input  logic [19:0]         raw_pressure_i,
  input  logic [15:0]         raw_humidity_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [17:0]  temperature_centideg_o,
  output logic [23:0]         pressure_pascal_o,
  output logic [13:0]         humidity_centipercent_o,
  output logic                pressure_divisor_zero_o
);

  coeffs_t   coeffs_q;
  raw_word_t in_word, q_word;
  logic      q_valid, q_pop;
  result_t   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeffs_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TEMP_COEFFS:    coeffs_q.temp_coeffs    <= cfg_data_i[47:0];
        CFG_PRESS_COEFFS_A: coeffs_q.press_coeffs_a <= cfg_data_i;
        CFG_PRESS_COEFFS_B: coeffs_q.press_coeffs_b <= cfg_data_i;
        CFG_MIXED_COEFFS:   coeffs_q.mixed_coeffs   <= cfg_data_i[47:0];
        CFG_HUM_COEFFS:     coeffs_q.hum_coeffs     <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  assign in_word.raw_temperature = raw_temperature_i;
  assign in_word.raw_pressure    = raw_pressure_i;
  assign in_word.raw_humidity    = raw_humidity_i;

  thpc_front #(.Depth(QUEUE_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .word_valid_o(q_valid),
    .word_o      (q_word),
    .word_pop_i  (q_pop)
  );

  thpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coeffs_i    (coeffs_q),
    .word_valid_i(q_valid),
    .word_i      (q_word),
    .word_pop_o  (q_pop),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign temperature_centideg_o  = $signed(res.temperature_centideg);
  assign pressure_pascal_o       = res.pressure_pascal;
  assign humidity_centipercent_o = res.humidity_centipercent;
  assign pressure_divisor_zero_o = res.pressure_divisor_zero;

  a_dz_forces_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pressure_divisor_zero_o |-> pressure_pascal_o == 24'd0)
    else $error("pressure not forced to zero on zero divisor");

  a_hum_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> humidity_centipercent_o <= 14'd10000)
    else $error("humidity above full scale");

endmodule

/* sim/thp_sensor_compensation_tb.sv */
`timescale 1ns / 1ps

module thp_sensor_compensation_tb;
  import thpc_pkg::*;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int          Drain      = 260;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd6;

  // expected compensated words and the coefficient copy that produces them
  class result_scoreboard;
    coeffs_t regs;
    result_t pending[$];
    int      errors;

    function new();
      regs = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_TEMP_COEFFS:    regs.temp_coeffs = data[47:0];
        CFG_PRESS_COEFFS_A: regs.press_coeffs_a = data;
        CFG_PRESS_COEFFS_B: regs.press_coeffs_b = data;
        CFG_MIXED_COEFFS:   regs.mixed_coeffs = data[47:0];
        CFG_HUM_COEFFS:     regs.hum_coeffs = data[39:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] asr32(bit [31:0] v, int n);
      return $unsigned($signed(v) >>> n);
    endfunction

    function bit [63:0] asr64(bit [63:0] v, int n);
      return $unsigned($signed(v) >>> n);
    endfunction

    function bit [31:0] sx32(bit [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    function bit [63:0] sx64(bit [15:0] v);
      return {{48{v[15]}}, v};
    endfunction

    // signed divide on bit patterns, truncating toward zero
    function bit [63:0] div_trunc(bit [63:0] num, bit [63:0] den);
      bit [63:0] mn, md, q;
      mn = num[63] ? -num : num;
      md = den[63] ? -den : den;
      q = mn / md;
      return (num[63] != den[63]) ? -q : q;
    endfunction

    function result_t compensate(raw_word_t w);
      bit [31:0] at, ah, t1, t2, t3, v1, v2, d, tf, tc;
      bit [31:0] h1, h2, h3, h4, h5, h6, x, a, b, c, e, s;
      bit [63:0] ap, p1, p2, p3, p4, p5, p6, p7, p8, p9, q1, q2, p, ps, pr;
      bit        zero_div;
      result_t   r;
      at = {12'd0, w.raw_temperature};
      ap = {44'd0, w.raw_pressure};
      ah = {16'd0, w.raw_humidity};
      t1 = {16'd0, regs.temp_coeffs[15:0]};
      t2 = sx32(regs.temp_coeffs[31:16]);
      t3 = sx32(regs.temp_coeffs[47:32]);
      p1 = {48'd0, regs.press_coeffs_a[15:0]};
      p2 = sx64(regs.press_coeffs_a[31:16]);
      p3 = sx64(regs.press_coeffs_a[47:32]);
      p4 = sx64(regs.press_coeffs_a[63:48]);
      p5 = sx64(regs.press_coeffs_b[15:0]);
      p6 = sx64(regs.press_coeffs_b[31:16]);
      p7 = sx64(regs.press_coeffs_b[47:32]);
      p8 = sx64(regs.press_coeffs_b[63:48]);
      p9 = sx64(regs.mixed_coeffs[15:0]);
      h1 = {24'd0, regs.mixed_coeffs[23:16]};
      h2 = sx32(regs.mixed_coeffs[39:24]);
      h3 = {24'd0, regs.mixed_coeffs[47:40]};
      h4 = sx32(regs.hum_coeffs[15:0]);
      h5 = sx32(regs.hum_coeffs[31:16]);
      h6 = {{24{regs.hum_coeffs[39]}}, regs.hum_coeffs[39:32]};

      v1 = asr32(((at >> 3) - (t1 << 1)) * t2, 11);
      d = (at >> 4) - t1;
      v2 = asr32(asr32(d * d, 12) * t3, 14);
      tf = v1 + v2;
      tc = asr32(tf * 32'd5 + 32'd128, 8);

      q1 = {{32{tf[31]}}, tf} - 64'd128000;
      q2 = q1 * q1 * p6;
      q2 = q2 + ((q1 * p5) << 17);
      q2 = q2 + (p4 << 35);
      q1 = asr64(q1 * q1 * p3, 8) + ((q1 * p2) << 12);
      q1 = asr64(((64'd1 << 47) + q1) * p1, 33);
      pr = '0;
      zero_div = (q1 == 64'd0);
      if (!zero_div) begin
        p = 64'd1048576 - ap;
        p = div_trunc(((p << 31) - q2) * 64'd3125, q1);
        ps = asr64(p, 13);
        q1 = asr64(p9 * ps * ps, 25);
        q2 = asr64(p8 * p, 19);
        p = asr64(p + q1 + q2, 8) + (p7 << 4);
        pr = asr64(p, 8);
      end

      x = tf - 32'd76800;
      a = asr32(((ah << 14) - (h4 << 20) - h5 * x) + 32'd16384, 15);
      b = asr32(x * h6, 10);
      c = asr32(x * h3, 11) + 32'd32768;
      e = asr32(b * c, 10) + 32'd2097152;
      e = asr32(e * h2 + 32'd8192, 14);
      x = a * e;
      s = asr32(x, 15);
      x = x - asr32(asr32(s * s, 7) * h1, 4);
      if (x[31]) x = '0;
      else if (x > 32'd419430400) x = 32'd419430400;

      r.temperature_centideg = tc[17:0];
      r.pressure_pascal = pr[23:0];
      r.humidity_centipercent = 14'(((x >> 12) * 32'd100) / 32'd1024);
      r.pressure_divisor_zero = zero_div;
      return r;
    endfunction

    function void note_word(raw_word_t w);
      pending.push_back(compensate(w));
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.temperature_centideg !== want.temperature_centideg) begin
        $display("%0t: temperature exp %0d got %0d", $time,
                 $signed(want.temperature_centideg), $signed(got.temperature_centideg));
        errors++;
      end
      if (got.pressure_pascal !== want.pressure_pascal) begin
        $display("%0t: pressure exp %0d got %0d", $time,
                 want.pressure_pascal, got.pressure_pascal);
        errors++;
      end
      if (got.humidity_centipercent !== want.humidity_centipercent) begin
        $display("%0t: humidity exp %0d got %0d", $time,
                 want.humidity_centipercent, got.humidity_centipercent);
        errors++;
      end
      if (got.pressure_divisor_zero !== want.pressure_divisor_zero) begin
        $display("%0t: divisor flag exp %0b got %0b", $time,
                 want.pressure_divisor_zero, got.pressure_divisor_zero);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [19:0]         raw_temperature_i;
  logic [19:0]         raw_pressure_i;
  logic [15:0]         raw_humidity_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic signed [17:0]  temperature_centideg_o;
  logic [23:0]         pressure_pascal_o;
  logic [13:0]         humidity_centipercent_o;
  logic                pressure_divisor_zero_o;

  result_scoreboard sb;
  bit               no_idle;
  int               stall_left;
  int unsigned      cycles;

  thp_sensor_compensation u_top (.*);

  always #2 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word({temperature_centideg_o, pressure_pascal_o,
                     humidity_centipercent_o, pressure_divisor_zero_o});
  end

  // back-pressure on the result side
  always @(negedge clk_i) begin
    if (!rst_ni || no_idle) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_gap() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_word(logic [19:0] t, logic [19:0] p, logic [15:0] h);
    int gap;
    gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_temperature_i <= t;
    raw_pressure_i <= p;
    raw_humidity_i <= h;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word({t, p, h});
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic load_regs(logic [63:0] tc, logic [63:0] pa, logic [63:0] pb,
                           logic [63:0] mc, logic [63:0] hc);
    write_reg(CFG_TEMP_COEFFS, tc);
    write_reg(CFG_PRESS_COEFFS_A, pa);
    write_reg(CFG_PRESS_COEFFS_B, pb);
    write_reg(CFG_MIXED_COEFFS, mc);
    write_reg(CFG_HUM_COEFFS, hc);
    // out-of-range index must leave everything alone
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  logic [63:0] tc_typ, pa_typ, pb_typ, mc_typ, hc_typ;

  initial begin
    logic [63:0] junk;
    int          r;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    raw_temperature_i = '0;
    raw_pressure_i = '0;
    raw_humidity_i = '0;
    no_idle = 1'b0;
    tc_typ = {16'd0, 16'(-1000), 16'd26435, 16'd27504};
    pa_typ = {16'd2855, 16'd3024, 16'(-10685), 16'd36477};
    pb_typ = {16'(-14600), 16'd15500, 16'(-7), 16'd140};
    mc_typ = {16'd0, 8'd0, 16'd362, 8'd75, 16'd6000};
    hc_typ = {24'd0, 8'd30, 16'd50, 16'd324};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // coefficients still at reset: zero divisor everywhere
    send_word('0, '0, '0);
    send_word('1, '1, '1);
    send_word(20'd519888, 20'd415148, 16'd30000);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_idle();

    load_regs({16'hBEEF, tc_typ[47:0]}, pa_typ, pb_typ, {16'h1234, mc_typ[47:0]},
              {24'hA5A5A5, hc_typ[39:0]});
    send_word('0, '0, '0);
    send_word('1, '1, '1);
    send_word('1, '0, '0);
    send_word('0, '1, '1);
    send_word(20'd519888, '0, 16'd30000);
    send_word(20'd519888, '1, 16'd30000);
    send_word(20'd519888, 20'd415148, '0);
    send_word(20'd519888, 20'd415148, '1);
    send_word(20'd440064, 20'd415148, 16'd60000);
    send_word(20'h80000, 20'h80000, 16'h8000);
    send_word(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
    send_word(20'h55555, 20'hAAAAA, 16'h5555);
    send_word(20'hAAAAA, 20'h55555, 16'hAAAA);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      junk = {$urandom, $urandom};
      case (ph)
        0: load_regs(tc_typ, pa_typ, pb_typ, mc_typ, hc_typ);
        1: load_regs(tc_typ ^ (junk & 64'hFF00FF), pa_typ ^ (junk & 64'h00FF00FF00FF00FF),
                     pb_typ ^ (junk & 64'h00FF00FF00FF00FF), mc_typ ^ (junk & 64'h0F00FF00FF),
                     hc_typ ^ (junk & 64'hFF00FF00FF));
        2: load_regs('1, '1, '1, '1, '1);
        3: load_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
        4: load_regs(tc_typ, {pa_typ[63:16], 16'd0}, pb_typ, mc_typ, hc_typ);
        default: load_regs(tc_typ, pa_typ, pb_typ,
                           {mc_typ[63:48], 8'(junk), mc_typ[39:0]}, hc_typ);
      endcase
      no_idle = (ph == 1);
      for (int i = 0; i < 160; i++) begin
        r = $urandom_range(0, 9);
        if (r < 7)
          send_word($urandom_range(400000, 600000), $urandom_range(250000, 500000),
                    $urandom_range(15000, 45000));
        else
          send_word($urandom, $urandom, $urandom);
      end
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      wait_idle();
      no_idle = 1'b0;
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/thpc_pkg.sv
src/thpc_front.sv
src/thpc_mul.sv
src/thpc_div.sv
src/thpc_back.sv
src/thp_sensor_compensation.sv
sim/thp_sensor_compensation_tb.sv
